>>> hdl/cht_pkg.sv
// cht_pkg: shared constants, status codes and controller/datapath
// command and status structs for the chained hash table core.
// No dependencies.
package cht_pkg;

  // Field widths of the stream payload
  localparam int KEY_W    = 31;
  localparam int REC_W    = 32;
  localparam int STATUS_W = 2;
  localparam int BIDX_W   = 7;
  localparam int BCNT_W   = 8;

  // Padded stream widths (whole bytes)
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;

  // Request kinds carried on s_tuser
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Defaults for the top-level parameters
  localparam int MAX_BUCKETS_DEF  = 128;
  localparam int BUCKET_DEPTH_DEF = 8;

  // Bucket count register value after reset
  localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 8'd100;

  // Modulo unit: key bits retired per cycle, and digit steps per key
  localparam int DIGIT     = 4;
  localparam int DIV_STEPS = (KEY_W + DIGIT - 1) / DIGIT;
  localparam int DIV_SH_W  = DIV_STEPS * DIGIT;

  // Result codes carried on m_tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;      // zero one fill counter, advance sweep
    logic load;       // capture input transaction, start modulo
    logic div_step;   // retire one digit of the key
    logic fill_rd;    // read fill counter of the bucket
    logic fill_eval;  // decide insert / start lookup
    logic scan;       // issue/compare one bucket entry
    logic emit;       // move result into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last; // sweep reaches the last fill counter
    logic div_last;   // last digit of the key this cycle
    logic need_scan;  // lookup on a non-empty bucket
    logic scan_end;   // match found or bucket exhausted
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

>>> hdl/cht_ctrl.sv
// cht_ctrl: sequencing state machine for the chained hash table core.
// Depends on cht_pkg (cmd_t, sts_t).
module cht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cht_pkg::sts_t sts,
  output cht_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_DIV     = 7'b0000100,
    S_FILL_RD = 7'b0001000,
    S_FILL    = 7'b0010000,
    S_SCAN    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_next = S_FILL_RD;
      end
      S_FILL_RD: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        state_next = sts.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.clear     = (state == S_CLEAR);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.div_step  = (state == S_DIV);
    cmd.fill_rd   = (state == S_FILL_RD);
    cmd.fill_eval = (state == S_FILL);
    cmd.scan      = (state == S_SCAN);
    cmd.emit      = (state == S_DONE) && sts.out_free;
  end

  assign in_ready = (state == S_IDLE);

endmodule

>>> hdl/cht_datapath.sv
// cht_datapath: modulo unit, fill counter memory, entry memory, scan
// compare and output register of the chained hash table core.
// Depends on cht_pkg (widths, status codes, cmd_t, sts_t).
module cht_datapath #(
  parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cht_pkg::cmd_t                 cmd,
  output cht_pkg::sts_t                 sts,
  // configuration
  input  logic                          cfg_valid,
  input  logic [cht_pkg::BCNT_W-1:0]    cfg_data,
  // request payload
  input  logic                          in_req_type,
  input  logic [cht_pkg::KEY_W-1:0]     in_key,
  input  logic [cht_pkg::REC_W-1:0]     in_record,
  // result
  input  logic                          out_ready,
  output logic                          out_valid,
  output cht_pkg::status_t              out_status,
  output logic [cht_pkg::REC_W-1:0]     out_data,
  output logic [cht_pkg::BIDX_W-1:0]    out_bucket
);

  localparam int KEY_W   = cht_pkg::KEY_W;
  localparam int REC_W   = cht_pkg::REC_W;
  localparam int BCNT_W  = cht_pkg::BCNT_W;
  localparam int DIGIT   = cht_pkg::DIGIT;
  localparam int SH_W    = cht_pkg::DIV_SH_W;
  localparam int STEPS   = cht_pkg::DIV_STEPS;
  localparam int CNT_W   = $clog2(MAX_BUCKETS + 1);
  localparam int R_W     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CMP_W   = (CNT_W > BCNT_W) ? CNT_W : BCNT_W;
  localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int ENTRIES = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int E_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DC_W    = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Configuration register
  logic [BCNT_W-1:0] bucket_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= cht_pkg::BUCKET_COUNT_RST;
    end else if (cfg_valid) begin
      bucket_count <= cfg_data;
    end
  end

  // Effective modulus: zero counts as one, saturate at MAX_BUCKETS
  logic [CNT_W-1:0] n_eff;

  always_comb begin
    if (bucket_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (CMP_W'(bucket_count) > CMP_W'(MAX_BUCKETS)) begin
      n_eff = CNT_W'(MAX_BUCKETS);
    end else begin
      n_eff = CNT_W'(bucket_count);
    end
  end

  // Captured request
  logic             req_q;
  logic [KEY_W-1:0] key_q;
  logic [REC_W-1:0] rec_q;
  logic [CNT_W-1:0] n_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= in_req_type;
      key_q <= in_key;
      rec_q <= in_record;
      n_q   <= n_eff;
    end
  end

  // Modulo unit: restoring remainder, DIGIT key bits per cycle, MSB first
  logic [SH_W-1:0] div_sh;
  logic [DC_W-1:0] div_cnt;
  logic [R_W-1:0]  rem;
  logic [R_W-1:0]  rem_next;
  logic [R_W:0]    n_ext;

  assign n_ext = (R_W + 1)'(n_q);

  always_comb begin
    logic [R_W:0]   t;
    logic [R_W-1:0] r;
    r = rem;
    t = '0;
    for (int i = 0; i < DIGIT; i++) begin
      t = {r, div_sh[SH_W-1-i]};
      if (t >= n_ext) t = t - n_ext;
      r = t[R_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_sh  <= SH_W'(in_key);
      div_cnt <= '0;
      rem     <= '0;
    end else if (cmd.div_step) begin
      div_sh  <= div_sh << DIGIT;
      div_cnt <= div_cnt + DC_W'(1);
      rem     <= rem_next;
    end
  end

  assign sts.div_last = (div_cnt == DC_W'(STEPS - 1));

  // Fill counter memory with clearing sweep after reset
  logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
  logic [FILL_W-1:0] fill_q;
  logic [R_W-1:0]    clr_cnt;
  logic [E_W-1:0]    base;
  logic              bucket_full;
  logic              ins_ok;

  assign bucket_full = (fill_q == FILL_W'(BUCKET_DEPTH));
  assign ins_ok      = cmd.fill_eval && (req_q == cht_pkg::REQ_INSERT) && !bucket_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + R_W'(1);
    end
  end

  assign sts.clear_last = (clr_cnt == R_W'(MAX_BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      fill_mem[clr_cnt] <= '0;
    end else if (ins_ok) begin
      fill_mem[rem] <= fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      fill_q <= fill_mem[rem];
      base   <= E_W'(rem) * E_W'(BUCKET_DEPTH);
    end
  end

  assign sts.need_scan = (req_q == cht_pkg::REQ_LOOKUP) && (fill_q != '0);

  // Entry memory: {key, record} per slot
  logic [KEY_W+REC_W-1:0] ent_mem [ENTRIES];
  logic [FILL_W-1:0]      rd_j;
  logic [E_W-1:0]         ent_addr;
  logic                   rd_issue;
  logic [KEY_W-1:0]       rd_key;
  logic [REC_W-1:0]       rd_rec;
  logic                   cmp_valid;
  logic                   cmp_last;
  logic                   cmp_hit;

  assign ent_addr = base + E_W'(cmd.fill_eval ? fill_q : rd_j);
  assign rd_issue = cmd.scan && (rd_j < fill_q);

  always_ff @(posedge clk) begin
    if (ins_ok) begin
      ent_mem[ent_addr] <= {key_q, rec_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      {rd_key, rd_rec} <= ent_mem[ent_addr];
    end
  end

  // Scan pipeline: issue read j, compare j in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_j      <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
    end else if (cmd.fill_eval) begin
      rd_j      <= '0;
      cmp_valid <= 1'b0;
      cmp_last  <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_issue) rd_j <= rd_j + FILL_W'(1);
      cmp_valid <= rd_issue;
      cmp_last  <= rd_issue && (rd_j == fill_q - FILL_W'(1));
    end
  end

  assign cmp_hit      = cmp_valid && (rd_key == key_q);
  assign sts.scan_end = cmp_valid && (cmp_hit || cmp_last);

  // Result register
  cht_pkg::status_t res_status;
  logic [REC_W-1:0] res_data;

  always_ff @(posedge clk) begin
    if (cmd.fill_eval) begin
      res_data <= '0;
      if (req_q == cht_pkg::REQ_INSERT) begin
        res_status <= bucket_full ? cht_pkg::ST_FULL : cht_pkg::ST_INSERTED;
      end else begin
        res_status <= cht_pkg::ST_MISSING;
      end
    end else if (cmd.scan && cmp_hit) begin
      res_status <= cht_pkg::ST_FOUND;
      res_data   <= rd_rec;
    end
  end

  // Output register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_bucket <= cht_pkg::BIDX_W'(rem);
    end
  end

endmodule

>>> hdl/chained_hash_table_core.sv
// chained_hash_table_core: top level of the chained hash table, keyed
// record store with per-bucket chains. Instantiates cht_ctrl and
// cht_datapath; depends on cht_pkg.
//
//   channel  direction  handshake             payload
//   s_       in         s_tvalid / s_tready   tuser: req_type; tdata: key, record_data
//   m_       out        m_tvalid / m_tready   tuser: status; tdata: found_data, bucket_index
//   cfg_     in         cfg_valid / cfg_ready cfg_data: bucket_count
//
// One request at a time. An insert runs the key modulo (4 key bits per
// cycle), fill counter read, decision, result hand-off and idle before
// the next accept. A lookup on a non-empty bucket adds a scan that stops
// at a match or after the last entry (one entry memory read per cycle).
// After reset the fill counters are swept to zero with s_tready low.
// A stalled m_tready holds the result in the output register; the next
// request is still accepted and waits at its end.
module chained_hash_table_core #(
  parameter int MAX_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cht_pkg::S_TDATA_W-1:0]    s_tdata,  // [30:0] key, [62:31] record_data
  input  logic                             s_tuser,  // [0] req_type
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cht_pkg::M_TDATA_W-1:0]    m_tdata,  // [31:0] found_data, [38:32] bucket_index
  output logic [cht_pkg::STATUS_W-1:0]     m_tuser,  // [1:0] status
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cht_pkg::BCNT_W-1:0]       cfg_data  // bucket_count
);

  localparam int KEY_W = cht_pkg::KEY_W;
  localparam int REC_W = cht_pkg::REC_W;

  cht_pkg::cmd_t                  cmd;
  cht_pkg::sts_t                  sts;
  cht_pkg::status_t               out_status;
  logic [REC_W-1:0]               out_data;
  logic [cht_pkg::BIDX_W-1:0]     out_bucket;

  assign cfg_ready = 1'b1;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cht_datapath #(
    .MAX_BUCKETS  (MAX_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_req_type (s_tuser),
    .in_key      (s_tdata[KEY_W-1:0]),
    .in_record   (s_tdata[KEY_W+REC_W-1:KEY_W]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_bucket  (out_bucket)
  );

  // Pack result stream
  assign m_tuser = out_status;
  assign m_tdata = {{(cht_pkg::M_TDATA_W - REC_W - cht_pkg::BIDX_W){1'b0}},
                    out_bucket, out_data};

endmodule

>>> hdl/cht_checker.sv
// cht_checker: port-level checks of chained_hash_table_core, bound to
// the top level. Depends on cht_pkg (status codes, widths).
module cht_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [cht_pkg::S_TDATA_W-1:0]    s_tdata,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cht_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic [cht_pkg::STATUS_W-1:0]     m_tuser,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [cht_pkg::BCNT_W-1:0]       cfg_data
);

  // Reset empties the output and starts the clearing sweep
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // One request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted back to back");

  // Record word is zero unless the key was found
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != cht_pkg::ST_FOUND) |-> m_tdata[cht_pkg::REC_W-1:0] == '0)
    else $error("nonzero record word without a match");

  // A new result never appears without a prior accepted request
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared straight from idle");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);

>>> verif/chained_hash_table_core_tb.sv
// chained_hash_table_core_tb: self-checking testbench for the chained hash table core.
// It drives insert and lookup transactions, predicts every result and checks it.
// Depends on cht_pkg and chained_hash_table_core.
module chained_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          KEY_W        = cht_pkg::KEY_W;
  localparam int          REC_W        = cht_pkg::REC_W;
  localparam int          BIDX_W       = cht_pkg::BIDX_W;
  localparam int          BCNT_W       = cht_pkg::BCNT_W;
  localparam int          STATUS_W     = cht_pkg::STATUS_W;
  localparam int          S_TDATA_W    = cht_pkg::S_TDATA_W;
  localparam int          M_TDATA_W    = cht_pkg::M_TDATA_W;
  localparam int          NUM_BUCKETS  = cht_pkg::MAX_BUCKETS_DEF;
  localparam int          CHAIN_DEPTH  = cht_pkg::BUCKET_DEPTH_DEF;
  localparam int          ENTRY_COUNT  = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          PRINT_LIMIT  = 40;
  localparam int          PHASE_ITEMS  = 205;
  localparam logic [30:0] KEY_MAX      = 31'h7FFF_FFFF;

  // Expected result of one request
  typedef struct packed {
    cht_pkg::status_t     status;
    logic [REC_W-1:0]     data;
    logic [BIDX_W-1:0]    bucket;
  } request_outcome_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [S_TDATA_W-1:0]    s_tdata   = '0;
  logic                    s_tuser   = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]    m_tdata;
  logic [STATUS_W-1:0]     m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [BCNT_W-1:0]       cfg_data  = '0;

  // Shadow copy of the table and the bucket count
  logic [BCNT_W-1:0]       shadow_count = cht_pkg::BUCKET_COUNT_RST;
  logic [3:0]              shadow_fill [NUM_BUCKETS];
  logic [KEY_W-1:0]        shadow_key  [ENTRY_COUNT];
  logic [REC_W-1:0]        shadow_rec  [ENTRY_COUNT];

  request_outcome_t        pending_results [$];
  request_outcome_t        oldest;
  logic [KEY_W-1:0]        key_pool [$];

  bit                      quiet        = 1'b0;
  int unsigned             ready_hold   = 0;
  int unsigned             cycle_count  = 0;
  int unsigned             mismatches   = 0;
  int unsigned             items_sent   = 0;
  int unsigned             count_writes = 0;
  int unsigned             n_inserted   = 0;
  int unsigned             n_refused    = 0;
  int unsigned             n_found      = 0;
  int unsigned             n_missing    = 0;

  chained_hash_table_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [30:0] key, [62:31] record_data
    .s_tuser   (s_tuser),   // [0] req_type
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [31:0] found_data, [38:32] bucket_index
    .m_tuser   (m_tuser),   // [1:0] status
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)   // bucket_count
  );

  always #1 clk = ~clk;

  initial begin
    for (int b = 0; b < NUM_BUCKETS; b++) shadow_fill[b] = '0;
  end

  // Table model: hash, then append or scan the chain
  function automatic request_outcome_t predict_request(input logic rt,
                                                       input logic [KEY_W-1:0] k,
                                                       input logic [REC_W-1:0] rec);
    request_outcome_t res;
    int unsigned      modulus;
    int unsigned      bkt;
    int unsigned      base;
    int unsigned      fill;
    int unsigned      key_u;
    bit               hit;
    modulus = shadow_count;
    if (modulus == 0) modulus = 1;
    if (modulus > NUM_BUCKETS) modulus = NUM_BUCKETS;
    key_u = k;
    bkt   = key_u % modulus;
    base  = bkt * CHAIN_DEPTH;
    fill  = shadow_fill[bkt];
    if (fill > CHAIN_DEPTH) fill = CHAIN_DEPTH;
    res.bucket = bkt[BIDX_W-1:0];
    res.data   = '0;
    if (rt == cht_pkg::REQ_INSERT) begin
      if (fill >= CHAIN_DEPTH) begin
        res.status = cht_pkg::ST_FULL;
      end else begin
        shadow_key[base + fill] = k;
        shadow_rec[base + fill] = rec;
        shadow_fill[bkt]        = 4'(fill + 1);
        res.status              = cht_pkg::ST_INSERTED;
      end
    end else begin
      res.status = cht_pkg::ST_MISSING;
      hit        = 1'b0;
      for (int j = 0; j < fill && !hit; j++) begin
        if (shadow_key[base + j] == k) begin
          hit        = 1'b1;
          res.status = cht_pkg::ST_FOUND;
          res.data   = shadow_rec[base + j];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // One request transaction; prediction taken at acceptance
  task automatic send_request(input logic rt, input logic [KEY_W-1:0] k,
                              input logic [REC_W-1:0] rec);
    request_outcome_t outcome;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rt;
    s_tdata  <= {1'b0, rec, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    outcome = predict_request(rt, k, rec);
    pending_results.insert(pending_results.size(), outcome);
    if (rt == cht_pkg::REQ_INSERT) key_pool.insert(key_pool.size(), k);
    items_sent++;
  endtask

  // Stop sending and wait until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [BCNT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_count = value;
    count_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_fresh_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0:       k = KEY_W'($urandom_range(0, 1023));
      1:       k = KEY_W'($urandom);
      2:       k = KEY_W'(KEY_MAX - $urandom_range(0, 300));
      default: k = KEY_W'($urandom_range(0, 40) * NUM_BUCKETS + $urandom_range(0, 2));
    endcase
    return k;
  endfunction

  function automatic logic [REC_W-1:0] pick_record();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return REC_W'($urandom);
    endcase
  endfunction

  // Empty bucket, key extremes, duplicate keys (earliest wins)
  task automatic test_basic_insert_lookup();
    send_request(cht_pkg::REQ_LOOKUP, 31'd5, 32'hDEAD_BEEF);
    send_request(cht_pkg::REQ_INSERT, 31'd0, 32'h0000_0000);
    send_request(cht_pkg::REQ_INSERT, KEY_MAX, 32'hFFFF_FFFF);
    send_request(cht_pkg::REQ_LOOKUP, 31'd0, 32'h0);
    send_request(cht_pkg::REQ_LOOKUP, KEY_MAX, 32'h0);
    send_request(cht_pkg::REQ_INSERT, 31'd0, 32'h1234_5678);
    send_request(cht_pkg::REQ_LOOKUP, 31'd0, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // Fill one chain to the depth, then one more insert is refused
  task automatic test_bucket_overflow();
    for (int i = 0; i <= CHAIN_DEPTH; i++)
      send_request(cht_pkg::REQ_INSERT, KEY_W'(5 + 100 * i), REC_W'(32'hA500_0000 + i));
    send_request(cht_pkg::REQ_LOOKUP, KEY_W'(5 + 100 * (CHAIN_DEPTH - 1)), 32'h0);
    send_request(cht_pkg::REQ_LOOKUP, KEY_W'(5 + 100 * CHAIN_DEPTH), 32'h0);
    drain_results();
  endtask

  // Zero count, saturated count, one bucket, full count; old entries stay put
  task automatic test_bucket_count_extremes();
    write_bucket_count(8'd0);
    send_request(cht_pkg::REQ_INSERT, 31'd12345, 32'h5A5A_A5A5);
    send_request(cht_pkg::REQ_LOOKUP, 31'd12345, 32'h0);
    send_request(cht_pkg::REQ_LOOKUP, 31'd0, 32'h0);
    write_bucket_count(8'd255);
    send_request(cht_pkg::REQ_LOOKUP, 31'd105, 32'h0);
    send_request(cht_pkg::REQ_INSERT, KEY_MAX, 32'hC3C3_3C3C);
    write_bucket_count(8'd1);
    send_request(cht_pkg::REQ_LOOKUP, 31'd5, 32'h0);
    write_bucket_count(8'd128);
    send_request(cht_pkg::REQ_LOOKUP, KEY_MAX, 32'h0);
    drain_results();
  endtask

  // Mostly lookups of stored keys, with inserts, misses and refused inserts
  task automatic test_random_traffic();
    logic [BCNT_W-1:0] settings [9];
    logic              rt;
    logic [KEY_W-1:0]  k;
    settings = '{8'd7, 8'd1, 8'd128, 8'd37, 8'd255, 8'd0, 8'd100, 8'd64, 8'd13};
    settings[8] = BCNT_W'($urandom_range(2, 127));
    for (int p = 0; p < 9; p++) begin
      write_bucket_count(settings[p]);
      quiet = (p == 8);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        rt = ($urandom_range(0, 9) < 4) ? cht_pkg::REQ_INSERT : cht_pkg::REQ_LOOKUP;
        if (rt == cht_pkg::REQ_LOOKUP && key_pool.size() != 0 && $urandom_range(0, 9) < 7)
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
          k = pick_fresh_key();
        send_request(rt, k, pick_record());
      end
    end
    drain_results();
  endtask

  // Result side: random stall bursts, none in the quiet stretch
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (m_tready) begin
      if ($urandom_range(0, 5) == 0) begin
        m_tready   <= 1'b0;
        ready_hold <= $urandom_range(0, 9);
      end
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 20);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", {30'b0, m_tuser}, 32'h0);
      end else begin
        oldest = pending_results.pop_front();
        if (m_tuser !== oldest.status)
          report_mismatch("status", {30'b0, m_tuser}, {30'b0, oldest.status});
        if (m_tdata[31:0] !== oldest.data)
          report_mismatch("found_data", m_tdata[31:0], oldest.data);
        if (m_tdata[38:32] !== oldest.bucket)
          report_mismatch("bucket_index", {25'b0, m_tdata[38:32]}, {25'b0, oldest.bucket});
        case (oldest.status)
          cht_pkg::ST_INSERTED: n_inserted++;
          cht_pkg::ST_FULL:     n_refused++;
          cht_pkg::ST_FOUND:    n_found++;
          default:              n_missing++;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_insert_lookup();
    test_bucket_overflow();
    test_bucket_count_extremes();
    test_random_traffic();
    repeat (40) @(posedge clk);
    $display("%0d requests under %0d bucket-count writes, %0d mismatches",
             items_sent, count_writes, mismatches);
    $display("results: %0d inserted, %0d refused, %0d found, %0d not found",
             n_inserted, n_refused, n_found, n_missing);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
